[hdl/aarm_pkg.sv]
// Shared constants, item types and arithmetic helpers for the axis-angle rotation matrix block.
package aarm_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

  localparam int NORM_STEPS = 5;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  // Angle path: five reduction/scale stages, the CORDIC row, one fold stage.
  localparam int ANGLE_DEPTH = 6 + CORDIC_STEPS;
  // Axis path: squares, sum, normalize, root, divide, sign/clamp.
  localparam int AXIS_DEPTH  = 3 + NORM_STEPS + SQRT_STEPS + DIV_STEPS;
  localparam int CS_ALIGN    = AXIS_DEPTH - ANGLE_DEPTH;
  localparam int PIPE_DEPTH  = AXIS_DEPTH + 3;

  // 92 full turns in Q16.16, lifts any 32-bit angle to a positive value.
  localparam logic [33:0] TURN_BIAS   = 34'd2170552320;
  // floor(v / 45) == (v * INV45) >> 20 for every v below 2^14.
  localparam logic [14:0] INV45       = 15'd23302;
  localparam logic [24:0] QUARTER_Q16 = 25'd5898240;
  localparam logic [24:0] HALF_Q16    = 25'd11796480;
  localparam logic [24:0] THREEQ_Q16  = 25'd17694720;
  // pi/180 in Q0.40, split into high and low halves at bit 18.
  localparam logic [16:0] DEG_RAD_HI  = 17'd73204;
  localparam logic [17:0] DEG_RAD_LO  = 18'd108693;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
  localparam logic [31:0]        ONE_Q30_U   = 32'd1073741824;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cord_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } sq_t;

  typedef struct packed {
    logic [31:0]       root;
    logic [2:0][63:0]  rem;
    logic [2:0][31:0]  quo;
  } div_t;

  typedef struct packed {
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic [2:0]  sgn;
    logic        zero;
  } ax_side_t;

  typedef struct packed {
    logic [2:0][31:0] mk;
    logic [2:0]       sgn;
    logic             zero;
  } sq_side_t;

  typedef struct packed {
    logic [2:0] sgn;
    logic       zero;
  } dv_side_t;

  function automatic logic signed [33:0] cordic_atan(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:    a = 34'sd843314857;
      5'd1:    a = 34'sd497837829;
      5'd2:    a = 34'sd263043837;
      5'd3:    a = 34'sd133525159;
      5'd4:    a = 34'sd67021687;
      5'd5:    a = 34'sd33543516;
      5'd6:    a = 34'sd16775851;
      5'd7:    a = 34'sd8388437;
      5'd8:    a = 34'sd4194283;
      5'd9:    a = 34'sd2097149;
      5'd10:   a = 34'sd1048576;
      5'd31:   a = 34'sd0;
      default: a = 34'sd1 <<< (5'd30 - i);
    endcase
    return a;
  endfunction

  // Q30 product, rounded half up (floor of product plus half).
  function automatic logic signed [34:0] mul30(input logic signed [34:0] a,
                                                input logic signed [34:0] b);
    logic signed [69:0] p;
    p = a * b + (70'sd1 <<< 29);
    return 35'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = 32'(ONE_Q30);
    end else if (v < -ONE_Q30) begin
      r = 32'(-ONE_Q30);
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

[hdl/axis_angle_rotation_matrix.sv]
// Top level: axis-angle to 3x3 rotation matrix pipeline (Rodrigues' formula).
// Throughput: one item per cycle unless stalled; the sqrt and divide rows set the depth.
// Stall: the whole pipeline holds while the output item waits and out_stall is high.
// Reset: rst_n (synchronous, active low) clears all valid bits; data registers are
// not reset. No clearing pass; items are accepted from the first cycle after reset.
module axis_angle_rotation_matrix (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_angle_deg,
  input  logic [31:0] in_axis_x,
  input  logic [31:0] in_axis_y,
  input  logic [31:0] in_axis_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_m00,
  output logic [31:0] out_m01,
  output logic [31:0] out_m02,
  output logic [31:0] out_m10,
  output logic [31:0] out_m11,
  output logic [31:0] out_m12,
  output logic [31:0] out_m20,
  output logic [31:0] out_m21,
  output logic [31:0] out_m22,
  output logic        out_zero_axis
);
  import aarm_pkg::*;

  // ---------------------------------------------------------------
  // Flow control: one enable for every stage. Advance unless the
  // last stage holds an item the consumer is not taking.
  // ---------------------------------------------------------------
  logic adv;
  logic [PIPE_DEPTH-1:0] val_r;
  logic [PIPE_DEPTH-1:0] val_nxt;

  assign adv      = !(val_r[PIPE_DEPTH-1] && out_stall);
  assign in_stall = !adv;

  always_comb begin
    val_nxt = {val_r[PIPE_DEPTH-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (adv) begin
      val_r <= val_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Angle path, stage 1: bias to a positive value, split off the
  // low 19 bits so that 360 deg in Q16.16 becomes 45 * 2^19.
  // ---------------------------------------------------------------
  logic [33:0] ang_u;
  logic [13:0] a1_v_r;
  logic [18:0] a1_lo_r;

  assign ang_u = 34'(signed'(in_angle_deg)) + TURN_BIAS;

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_v_r  <= ang_u[32:19];
      a1_lo_r <= ang_u[18:0];
    end
  end

  // Stage 2: reduce the upper part modulo 45 by reciprocal multiply.
  logic [28:0] a2_prod;
  logic [8:0]  a2_qv;
  logic [13:0] a2_rem;
  logic [5:0]  a2_rem_r;
  logic [18:0] a2_lo_r;

  always_comb begin
    a2_prod = 29'(a1_v_r) * 29'(INV45);
    a2_qv   = a2_prod[28:20];
    a2_rem  = a1_v_r - 14'(a2_qv) * 14'd45;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_rem_r <= a2_rem[5:0];
      a2_lo_r  <= a1_lo_r;
    end
  end

  // Stage 3: pick the quadrant and the remainder within it.
  logic [24:0] a3_r;
  logic [1:0]  a3_q;
  logic [24:0] a3_f;
  logic [1:0]  a3_q_r;
  logic [22:0] a3_f_r;

  always_comb begin
    a3_r = {a2_rem_r, a2_lo_r};
    if (a3_r >= THREEQ_Q16) begin
      a3_q = 2'd3;
      a3_f = a3_r - THREEQ_Q16;
    end else if (a3_r >= HALF_Q16) begin
      a3_q = 2'd2;
      a3_f = a3_r - HALF_Q16;
    end else if (a3_r >= QUARTER_Q16) begin
      a3_q = 2'd1;
      a3_f = a3_r - QUARTER_Q16;
    end else begin
      a3_q = 2'd0;
      a3_f = a3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a3_q_r <= a3_q;
      a3_f_r <= a3_f[22:0];
    end
  end

  // Stage 4: degrees to radians, two partial products of f * pi/180.
  logic [39:0] a4_ph_r;
  logic [40:0] a4_pl_r;
  logic [1:0]  a4_q_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a4_ph_r <= 40'(a3_f_r) * 40'(DEG_RAD_HI);
      a4_pl_r <= 41'(a3_f_r) * 41'(DEG_RAD_LO);
      a4_q_r  <= a3_q_r;
    end
  end

  // Stage 5: combine partial products and round to Q2.30.
  logic [58:0] a5_sum;
  logic [32:0] a5_theta_r;
  logic [1:0]  a5_q_r;

  assign a5_sum = {1'b0, a4_ph_r, 18'd0} + 59'(a4_pl_r) + (59'd1 << 25);

  always_ff @(posedge clk) begin
    if (adv) begin
      a5_theta_r <= a5_sum[58:26];
      a5_q_r     <= a4_q_r;
    end
  end

  // CORDIC row: one micro-rotation per cell; carry the quadrant along.
  cord_t cord_c [CORDIC_STEPS+1];
  logic [1:0] cq_r [CORDIC_STEPS];

  assign cord_c[0] = '{x: CORDIC_GAIN, y: 34'sd0, z: signed'({1'b0, a5_theta_r})};

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    aarm_cordic_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .step (5'(j)),
      .din  (cord_c[j]),
      .dout (cord_c[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cq_r[0] <= a5_q_r;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        cq_r[i] <= cq_r[i-1];
      end
    end
  end

  // Fold: clamp and map the first-quadrant pair to the full angle.
  logic signed [31:0] xc;
  logic signed [31:0] yc;
  logic signed [31:0] fc;
  logic signed [31:0] fs;
  logic signed [31:0] cs_c_r [CS_ALIGN+1];
  logic signed [31:0] cs_s_r [CS_ALIGN+1];

  always_comb begin
    xc = clamp_q30(36'(cord_c[CORDIC_STEPS].x));
    yc = clamp_q30(36'(cord_c[CORDIC_STEPS].y));
    case (cq_r[CORDIC_STEPS-1])
      2'd0: begin
        fc = xc;
        fs = yc;
      end
      2'd1: begin
        fc = -yc;
        fs = xc;
      end
      2'd2: begin
        fc = -xc;
        fs = -yc;
      end
      default: begin
        fc = yc;
        fs = -xc;
      end
    endcase
  end

  // Hold cosine/sine in a delay line until the unit axis catches up.
  always_ff @(posedge clk) begin
    if (adv) begin
      cs_c_r[0] <= fc;
      cs_s_r[0] <= fs;
      for (int i = 1; i <= CS_ALIGN; i++) begin
        cs_c_r[i] <= cs_c_r[i-1];
        cs_s_r[i] <= cs_s_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Axis path, stage 1: magnitudes and their squares.
  // ---------------------------------------------------------------
  logic [31:0] mag [3];
  logic [31:0] vin [3];
  logic [63:0] sqr_r [3];
  ax_side_t    side1_r;

  assign vin[0] = in_axis_x;
  assign vin[1] = in_axis_y;
  assign vin[2] = in_axis_z;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = vin[l][31] ? (32'd0 - vin[l]) : vin[l];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        sqr_r[l] <= 64'(mag[l]) * 64'(mag[l]);
      end
      side1_r <= '{mx: mag[0], my: mag[1], mz: mag[2],
                   sgn: {in_axis_z[31], in_axis_y[31], in_axis_x[31]},
                   zero: (in_axis_x == '0) && (in_axis_y == '0) && (in_axis_z == '0)};
    end
  end

  // Stage 2 and the normalize row: sum, then shift left by 2k so the
  // top two bits are not both zero (binary search, 16/8/4/2/1).
  logic [63:0] nrm_s_r    [NORM_STEPS+1];
  logic [4:0]  nrm_k_r    [NORM_STEPS+1];
  ax_side_t    nrm_side_r [NORM_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      nrm_s_r[0]    <= sqr_r[0] + sqr_r[1] + sqr_r[2];
      nrm_k_r[0]    <= '0;
      nrm_side_r[0] <= side1_r;
    end
  end

  for (genvar j = 1; j <= NORM_STEPS; j++) begin : g_norm
    localparam int B = 32 >> j;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (nrm_s_r[j-1][63 -: 2*B] == '0) begin
          nrm_s_r[j] <= nrm_s_r[j-1] << (2*B);
          nrm_k_r[j] <= nrm_k_r[j-1] | 5'(B);
        end else begin
          nrm_s_r[j] <= nrm_s_r[j-1];
          nrm_k_r[j] <= nrm_k_r[j-1];
        end
        nrm_side_r[j] <= nrm_side_r[j-1];
      end
    end
  end

  // Square-root row; scaled magnitudes travel alongside.
  sq_t      sq_c [SQRT_STEPS+1];
  sq_side_t sq_side_r [SQRT_STEPS];
  ax_side_t nside;
  logic [4:0] nk;

  assign nside   = nrm_side_r[NORM_STEPS];
  assign nk      = nrm_k_r[NORM_STEPS];
  assign sq_c[0] = '{n: nrm_s_r[NORM_STEPS], res: 64'd0};

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    aarm_sqrt_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .step (5'(j)),
      .din  (sq_c[j]),
      .dout (sq_c[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= '{mk: {nside.mz << nk, nside.my << nk, nside.mx << nk},
                        sgn: nside.sgn, zero: nside.zero};
      for (int i = 1; i < SQRT_STEPS; i++) begin
        sq_side_r[i] <= sq_side_r[i-1];
      end
    end
  end

  // Divide row: u = (m * 2^(k+30) + R/2) / R for all three lanes.
  div_t       dv_c [DIV_STEPS+1];
  dv_side_t   dv_side_r [DIV_STEPS];
  logic [31:0] root;
  sq_side_t   sqs;

  assign root = sq_c[SQRT_STEPS].res[31:0];
  assign sqs  = sq_side_r[SQRT_STEPS-1];

  always_comb begin
    dv_c[0].root = root;
    for (int l = 0; l < 3; l++) begin
      dv_c[0].rem[l] = ({32'd0, sqs.mk[l]} << 30) + {33'd0, root[31:1]};
      dv_c[0].quo[l] = '0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    aarm_div_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .qbit (5'(DIV_STEPS - 1 - j)),
      .din  (dv_c[j]),
      .dout (dv_c[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0] <= '{sgn: sqs.sgn, zero: sqs.zero};
      for (int i = 1; i < DIV_STEPS; i++) begin
        dv_side_r[i] <= dv_side_r[i-1];
      end
    end
  end

  // Unit axis: clamp to one and restore the sign.
  logic [31:0]        qc [3];
  logic signed [31:0] u_r [3];
  logic               u_zero_r;
  dv_side_t           dvs;

  assign dvs = dv_side_r[DIV_STEPS-1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qc[l] = (dv_c[DIV_STEPS].quo[l] > ONE_Q30_U) ? ONE_Q30_U : dv_c[DIV_STEPS].quo[l];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        u_r[l] <= dvs.sgn[l] ? -signed'(qc[l]) : signed'(qc[l]);
      end
      u_zero_r <= dvs.zero;
    end
  end

  // ---------------------------------------------------------------
  // Matrix, stage P1: axis outer products and axis times sine.
  // ---------------------------------------------------------------
  logic signed [34:0] ux;
  logic signed [34:0] uy;
  logic signed [34:0] uz;
  logic signed [34:0] sn;
  logic signed [34:0] p1_xx_r, p1_yy_r, p1_zz_r, p1_xy_r, p1_xz_r, p1_yz_r;
  logic signed [34:0] p1_xs_r, p1_ys_r, p1_zs_r;
  logic signed [31:0] p1_c_r;
  logic               p1_zero_r;

  assign ux = 35'(u_r[0]);
  assign uy = 35'(u_r[1]);
  assign uz = 35'(u_r[2]);
  assign sn = 35'(cs_s_r[CS_ALIGN]);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_xx_r   <= mul30(ux, ux);
      p1_yy_r   <= mul30(uy, uy);
      p1_zz_r   <= mul30(uz, uz);
      p1_xy_r   <= mul30(ux, uy);
      p1_xz_r   <= mul30(ux, uz);
      p1_yz_r   <= mul30(uy, uz);
      p1_xs_r   <= mul30(ux, sn);
      p1_ys_r   <= mul30(uy, sn);
      p1_zs_r   <= mul30(uz, sn);
      p1_c_r    <= cs_c_r[CS_ALIGN];
      p1_zero_r <= u_zero_r;
    end
  end

  // Stage P2: diagonal terms and (1 - c) scaled off-diagonal terms.
  logic signed [34:0] c35;
  logic signed [34:0] t35;
  logic signed [34:0] one35;
  logic signed [34:0] p2_d0_r, p2_d1_r, p2_d2_r, p2_xy_r, p2_xz_r, p2_yz_r;
  logic signed [34:0] p2_xs_r, p2_ys_r, p2_zs_r;
  logic               p2_zero_r;

  assign one35 = 35'(ONE_Q30);
  assign c35   = 35'(p1_c_r);
  assign t35   = one35 - c35;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_d0_r   <= p1_xx_r + mul30(c35, one35 - p1_xx_r);
      p2_d1_r   <= p1_yy_r + mul30(c35, one35 - p1_yy_r);
      p2_d2_r   <= p1_zz_r + mul30(c35, one35 - p1_zz_r);
      p2_xy_r   <= mul30(p1_xy_r, t35);
      p2_xz_r   <= mul30(p1_xz_r, t35);
      p2_yz_r   <= mul30(p1_yz_r, t35);
      p2_xs_r   <= p1_xs_r;
      p2_ys_r   <= p1_ys_r;
      p2_zs_r   <= p1_zs_r;
      p2_zero_r <= p1_zero_r;
    end
  end

  // Stage P3: add the skew part, clamp, and drop in identity for a zero axis.
  logic signed [31:0] m_nxt [9];
  logic signed [31:0] m_r   [9];
  logic               zero_r;

  always_comb begin
    m_nxt[0] = clamp_q30(36'(p2_d0_r));
    m_nxt[1] = clamp_q30(36'(p2_xy_r) - 36'(p2_zs_r));
    m_nxt[2] = clamp_q30(36'(p2_xz_r) + 36'(p2_ys_r));
    m_nxt[3] = clamp_q30(36'(p2_xy_r) + 36'(p2_zs_r));
    m_nxt[4] = clamp_q30(36'(p2_d1_r));
    m_nxt[5] = clamp_q30(36'(p2_yz_r) - 36'(p2_xs_r));
    m_nxt[6] = clamp_q30(36'(p2_xz_r) - 36'(p2_ys_r));
    m_nxt[7] = clamp_q30(36'(p2_yz_r) + 36'(p2_xs_r));
    m_nxt[8] = clamp_q30(36'(p2_d2_r));
    if (p2_zero_r) begin
      for (int e = 0; e < 9; e++) begin
        m_nxt[e] = (e % 4 == 0) ? 32'(ONE_Q30) : 32'sd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 9; e++) begin
        m_r[e] <= m_nxt[e];
      end
      zero_r <= p2_zero_r;
    end
  end

  assign out_valid     = val_r[PIPE_DEPTH-1];
  assign out_m00       = m_r[0];
  assign out_m01       = m_r[1];
  assign out_m02       = m_r[2];
  assign out_m10       = m_r[3];
  assign out_m11       = m_r[4];
  assign out_m12       = m_r[5];
  assign out_m20       = m_r[6];
  assign out_m21       = m_r[7];
  assign out_m22       = m_r[8];
  assign out_zero_axis = zero_r;

endmodule

[hdl/aarm_cordic_cell.sv]
// One rotation-mode CORDIC micro-rotation stage with its output register.
module aarm_cordic_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     step,
  input  aarm_pkg::cord_t din,
  output aarm_pkg::cord_t dout
);
  import aarm_pkg::*;

  cord_t dout_r;
  cord_t dout_nxt;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] ang;

  always_comb begin
    dx  = din.y >>> step;
    dy  = din.x >>> step;
    ang = cordic_atan(step);
    if (!din.z[33]) begin
      dout_nxt.x = din.x - dx;
      dout_nxt.y = din.y + dy;
      dout_nxt.z = din.z - ang;
    end else begin
      dout_nxt.x = din.x + dx;
      dout_nxt.y = din.y - dy;
      dout_nxt.z = din.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

[hdl/aarm_sqrt_cell.sv]
// One digit of the bit-by-bit integer square root with its output register.
module aarm_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    step,
  input  aarm_pkg::sq_t din,
  output aarm_pkg::sq_t dout
);
  import aarm_pkg::*;

  sq_t dout_r;
  sq_t dout_nxt;
  logic [63:0] one;
  logic [63:0] trial;

  always_comb begin
    one   = 64'd1 << (6'd62 - {step, 1'b0});
    trial = din.res + one;
    if (din.n >= trial) begin
      dout_nxt.n   = din.n - trial;
      dout_nxt.res = (din.res >> 1) + one;
    end else begin
      dout_nxt.n   = din.n;
      dout_nxt.res = din.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

[hdl/aarm_div_cell.sv]
// One quotient bit of a three-lane restoring divider sharing one divisor.
module aarm_div_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     qbit,
  input  aarm_pkg::div_t din,
  output aarm_pkg::div_t dout
);
  import aarm_pkg::*;

  div_t dout_r;
  div_t dout_nxt;
  logic [63:0] dvs;

  always_comb begin
    dvs      = {32'd0, din.root} << qbit;
    dout_nxt = din;
    for (int l = 0; l < 3; l++) begin
      if (din.rem[l] >= dvs) begin
        dout_nxt.rem[l]       = din.rem[l] - dvs;
        dout_nxt.quo[l][qbit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

[hdl/aarm_checker.sv]
// Port-level checks for the rotation matrix block, bound to the top level.
module aarm_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] in_angle_deg,
  input logic [31:0] in_axis_x,
  input logic [31:0] in_axis_y,
  input logic [31:0] in_axis_z,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_m00,
  input logic [31:0] out_m01,
  input logic [31:0] out_m02,
  input logic [31:0] out_m10,
  input logic [31:0] out_m11,
  input logic [31:0] out_m12,
  input logic [31:0] out_m20,
  input logic [31:0] out_m21,
  input logic [31:0] out_m22,
  input logic        out_zero_axis
);

  // Hold the result while the consumer stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_m00) && $stable(out_m11) && $stable(out_m22)
      && $stable(out_m01) && $stable(out_zero_axis))
    else $error("stalled result item changed");

  // Back-pressure only comes from a waiting result.
  a_in_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // A zero axis gives the identity.
  a_zero_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_axis |-> out_m00 == 32'h4000_0000 && out_m11 == 32'h4000_0000
      && out_m22 == 32'h4000_0000 && out_m01 == '0 && out_m02 == '0 && out_m10 == '0
      && out_m12 == '0 && out_m20 == '0 && out_m21 == '0)
    else $error("zero axis did not give identity");

  // The first diagonal entry (m00) stays within plus or minus one.
  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_m00) <= 32'sh4000_0000 && $signed(out_m00) >= -32'sh4000_0000)
    else $error("diagonal entry out of range");

endmodule

bind axis_angle_rotation_matrix aarm_port_checks u_aarm_port_checks (.*);

[tb/aarm_checker.sv]
// Checker for the axis-angle rotation matrix block: predicts every result item and compares.
`timescale 1ns / 1ps
module aarm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_angle_deg,
  input  logic [31:0] in_axis_x,
  input  logic [31:0] in_axis_y,
  input  logic [31:0] in_axis_z,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_m00,
  input  logic [31:0] out_m01,
  input  logic [31:0] out_m02,
  input  logic [31:0] out_m10,
  input  logic [31:0] out_m11,
  input  logic [31:0] out_m12,
  input  logic [31:0] out_m20,
  input  logic [31:0] out_m21,
  input  logic [31:0] out_m22,
  input  logic        out_zero_axis,
  output int          errors,
  output int          pending
);
  import aarm_pkg::*;

  typedef struct packed {
    logic [8:0][31:0] m;
    logic             zero;
  } matrix_t;

  localparam longint ONE = 64'sd1 << 30;

  matrix_t matrix_q[$];

  function automatic longint sat_one(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint atan_q30(int i);
    longint tbl [11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i <= 10) return tbl[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_part(longint v, int k, longint unsigned root);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    mag = mag << k;
    q = ((mag << 30) + (root >> 1)) / root;
    if (q > 64'd1073741824) q = 64'd1073741824;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic matrix_t predict_matrix(logic [31:0] ang, logic [31:0] ax,
                                             logic [31:0] ay, logic [31:0] az);
    matrix_t res;
    longint a, vx, vy, vz, r, f, x, y, z, dx, dy, c, s, t;
    longint ux, uy, uz, xx, yy, zz, xy, xz, yz;
    longint unsigned sq, root, theta, d;
    longint e [9];
    int q, k, steps;
    a = longint'($signed(ang));
    vx = longint'($signed(ax));
    vy = longint'($signed(ay));
    vz = longint'($signed(az));
    sq = longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz);
    if (sq == 0) begin
      res.m = '0;
      res.m[0] = 32'd1073741824;
      res.m[4] = 32'd1073741824;
      res.m[8] = 32'd1073741824;
      res.zero = 1'b1;
      return res;
    end
    r = a % (64'sd360 << 16);
    if (r < 0) r += 64'sd360 << 16;
    q = int'(r / (64'sd90 << 16));
    f = r % (64'sd90 << 16);
    d = ((64'h3243F6A8885A308D / 64'd180) + (64'd1 << 19)) >> 20;
    theta = (longint'(f) * d + (64'd1 << 25)) >> 26;
    x = 652032874;
    y = 0;
    z = longint'(theta);
    steps = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30(i);
      end else begin
        x += dx; y -= dy; z += atan_q30(i);
      end
    end
    x = sat_one(x);
    y = sat_one(y);
    case (q & 3)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    k = 0;
    while (sq < (64'd1 << 62)) begin
      sq <<= 2;
      k++;
    end
    root = int_sqrt(sq);
    ux = unit_part(vx, k, root);
    uy = unit_part(vy, k, root);
    uz = unit_part(vz, k, root);
    t = ONE - c;
    xx = qmul(ux, ux); yy = qmul(uy, uy); zz = qmul(uz, uz);
    xy = qmul(ux, uy); xz = qmul(ux, uz); yz = qmul(uy, uz);
    e[0] = xx + qmul(c, ONE - xx);
    e[1] = qmul(xy, t) - qmul(uz, s);
    e[2] = qmul(xz, t) + qmul(uy, s);
    e[3] = qmul(xy, t) + qmul(uz, s);
    e[4] = yy + qmul(c, ONE - yy);
    e[5] = qmul(yz, t) - qmul(ux, s);
    e[6] = qmul(xz, t) - qmul(uy, s);
    e[7] = qmul(yz, t) + qmul(ux, s);
    e[8] = zz + qmul(c, ONE - zz);
    for (int j = 0; j < 9; j++) res.m[j] = 32'(sat_one(e[j]));
    res.zero = 1'b0;
    return res;
  endfunction

  assign pending = matrix_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    matrix_t got, want;
    if (rst_n && in_valid && !in_stall)
      matrix_q.push_back(predict_matrix(in_angle_deg, in_axis_x, in_axis_y, in_axis_z));
    if (rst_n && out_valid && !out_stall) begin
      got.m = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10, out_m02, out_m01,
               out_m00};
      got.zero = out_zero_axis;
      if (matrix_q.size() == 0) begin
        $display("%0t: result item with nothing expected", $time);
        errors++;
      end else begin
        want = matrix_q.pop_front();
        for (int j = 0; j < 9; j++)
          if (got.m[j] !== want.m[j]) begin
            $display("%0t: m%0d%0d expected %h actual %h", $time, j / 3, j % 3,
                     want.m[j], got.m[j]);
            errors++;
          end
        if (got.zero !== want.zero) begin
          $display("%0t: zero_axis expected %b actual %b", $time, want.zero, got.zero);
          errors++;
        end
      end
    end
  end
endmodule

[tb/axis_angle_rotation_matrix_tb.sv]
// Testbench top: drives items into the rotation matrix block and gives the verdict.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_angle_deg = '0, in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic [31:0] out_m20, out_m21, out_m22;
  logic        out_zero_axis;
  int          errors, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          quiet_cycles = 0;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  axis_angle_rotation_matrix dut (.*);

  aarm_checker u_checker (.*);

  // Receiver: stall at random with the current phase's rate.
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(logic [31:0] ang, logic [31:0] ax, logic [31:0] ay,
                           logic [31:0] az);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle_deg <= ang;
    in_axis_x <= ax;
    in_axis_y <= ay;
    in_axis_z <= az;
    do @(posedge clk); while (in_stall);
  endtask

  // Pick a component: half full range, the rest small, extreme or zero.
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return 32'($signed($urandom_range(200)) - 100);
      3:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      4:       return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int n);
    logic [31:0] ang;
    for (int i = 0; i < n; i++) begin
      // Favor angles near quadrant edges now and then.
      if ($urandom_range(3) == 0)
        ang = 32'($signed($urandom_range(8)) * (90 << 16) + $signed($urandom_range(4)) - 2
                  - (360 << 16));
      else
        ang = $urandom;
      if ($urandom_range(19) == 0)
        send_item(ang, '0, '0, '0);
      else
        send_item(ang, rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero axis, quadrant edges, extreme angles and axes.
    send_item(32'h0012_0000, '0, '0, '0);
    send_item(32'h8000_0000, '0, '0, '0);
    send_item('0, 32'h0001_0000, '0, '0);
    send_item(32'h005a_0000, '0, 32'h0001_0000, '0);
    send_item(32'h00b4_0000, '0, '0, 32'h0001_0000);
    send_item(32'h010e_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(32'h0168_0000, 32'hffff_0000, '0, '0);
    send_item(32'hffff_ffff, 32'd1, '0, '0);
    send_item(32'h0059_ffff, '0, 32'hffff_ffff, '0);
    send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(32'hff4c_0000, 32'h8000_0000, 32'h7fff_ffff, 32'd1);
    send_item(32'hffa6_0000, 32'd1, 32'd1, 32'd1);
    send_item(32'h002d_0000, 32'h0003_0000, 32'hfffc_0000, '0);
    send_item(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff);
    send_item(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0001);

    // Pause until every expected result is back.
    wait_drained();

    send_idle_pct = 12; recv_stall_pct = 88;
    send_random(280);
    wait_drained();
    send_idle_pct = 88; recv_stall_pct = 12;
    send_random(280);
    wait_drained();
    send_idle_pct = 0; recv_stall_pct = 0;
    send_random(290);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
